FILE: sv/pgm_pkg.sv
// Shared types and constants of the PGM stream parser.
package pgm_pkg;

  localparam int unsigned MaxDim   = 65535;
  localparam logic [16:0] DimLimit = (MaxDim < 65535) ? 17'(MaxDim) : 17'd65535;
  localparam logic [16:0] TokenCap = 17'd131071;

  typedef enum logic [3:0] {
    PH_MAGIC     = 4'd0,
    PH_WIDTH     = 4'd1,
    PH_HEIGHT    = 4'd2,
    PH_MAXVAL    = 4'd3,
    PH_PIX_ASCII = 4'd4,
    PH_PIX_BIN   = 4'd5,
    PH_DONE      = 4'd6,
    PH_ERROR     = 4'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MAGIC     = 3'd0,
    ERR_TOKEN     = 3'd1,
    ERR_HEADER    = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] Ch2    = 8'h32;
  localparam logic [7:0] Ch5    = 8'h35;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [16:0] MaxVal = 17'd255;

  // Classified byte request passed from front to back.
  typedef struct packed {
    logic       eof;
    logic       ws;
    logic       is_hash;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic       is_minus;
    logic [7:0] data;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pixel_value;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] width;
    logic [15:0] height;
    logic        binary_format;
    logic [2:0]  error_code;
    logic        image_done;
    logic        last_of_run;
  } res_t;

  localparam int ResW = $bits(res_t);

endpackage

FILE: sv/pgm_front.sv
// Front end: accepts input bytes, classifies them, small request queue.
module pgm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          in_eof_i,
  input  logic [7:0]    in_data_i,
  output logic          req_valid_o,
  input  logic          req_ready_i,
  output pgm_pkg::req_t req_o
);
  import pgm_pkg::*;

  req_t       slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  req_t       cls;
  logic       push, pop;

  always_comb begin
    cls.eof      = in_eof_i;
    cls.data     = in_data_i;
    cls.is_hash  = in_data_i == ChHash;
    cls.is_cr    = in_data_i == ChCr;
    cls.is_lf    = in_data_i == ChLf;
    cls.is_minus = in_data_i == ChMinus;
    cls.is_digit = (in_data_i >= Ch0) && (in_data_i <= Ch9);
    cls.ws       = (in_data_i == 8'h20) || (in_data_i >= 8'h09 && in_data_i <= 8'h0d)
                   || cls.is_hash;
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o       = slot_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (pop) begin
      rd_d = ~rd_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cls;
    end
  end
endmodule

FILE: sv/pgm_back.sv
// Back end: token assembly, header checks, pixel counting and result queue.
module pgm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  pgm_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output pgm_pkg::res_t res_o
);
  import pgm_pkg::*;

  phase_e      phase_q, phase_d;
  logic        cmt_q, cmt_d, tok_q, tok_d, acr_q, acr_d;
  logic [16:0] val_q, val_d;
  logic        sign_q, sign_d, dig_q, dig_d, bad_q, bad_d, mag_q, mag_d;
  logic [1:0]  mc_q, mc_d;
  logic [15:0] w_q, w_d, h_q, h_d, c_q, c_d, r_q, r_d;
  logic        fb_q, fb_d;

  // Result queue of four entries.
  res_t        rq_q [4];
  logic [1:0]  rrd_q, rwr_q;
  logic [2:0]  rcnt_q;
  logic [1:0]  n_res;
  res_t        ra, rb;
  logic        go, pop;

  assign req_ready_o = rcnt_q <= 3'd2;
  assign go          = req_valid_i && req_ready_o;
  assign res_valid_o = rcnt_q != 3'd0;
  assign res_o       = rq_q[rrd_q];
  assign pop         = res_valid_o && res_ready_i;

  // Token end evaluation on current state.
  logic        neg;
  logic        dim_ok;

  assign neg    = sign_q && (val_q != 17'd0);
  assign dim_ok = !neg && (val_q >= 17'd1) && (val_q <= DimLimit);

  function automatic res_t mk(kind_e k, logic [7:0] p, logic [15:0] c, logic [15:0] r,
                              logic [15:0] w, logic [15:0] h, logic f, err_e e,
                              logic d);
    res_t t;
    t.kind = k;
    t.pixel_value = p;
    t.col = c;
    t.row = r;
    t.width = w;
    t.height = h;
    t.binary_format = f;
    t.error_code = e;
    t.image_done = d;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  logic [20:0] prod;
  assign prod = {4'd0, val_q} * 21'd10 + {13'd0, req_i.data - Ch0};

  always_comb begin
    logic [15:0] cn, rn;
    logic        done;
    logic [7:0]  pv;
    logic        do_pix;
    res_t        t;
    phase_d = phase_q;
    cmt_d = cmt_q; tok_d = tok_q; acr_d = acr_q;
    val_d = val_q; sign_d = sign_q; dig_d = dig_q; bad_d = bad_q; mag_d = mag_q;
    mc_d = mc_q; w_d = w_q; h_d = h_q; c_d = c_q; r_d = r_q; fb_d = fb_q;
    n_res = 2'd0;
    ra = '0;
    rb = '0;
    do_pix = 1'b0;
    pv = 8'd0;
    t = '0;
    cn = c_q + 16'd1;
    rn = r_q;
    done = 1'b0;
    if (cn >= w_q) begin
      cn = 16'd0;
      rn = r_q + 16'd1;
      done = rn >= h_q;
    end

    // Token end (shared by eof and whitespace).
    if ((req_i.eof || (req_i.ws && phase_q != PH_DONE && phase_q != PH_ERROR && !cmt_q
        && phase_q != PH_PIX_BIN)) && tok_q && phase_q <= PH_PIX_ASCII) begin
      tok_d = 1'b0; val_d = '0; sign_d = 1'b0; dig_d = 1'b0; bad_d = 1'b0;
      mag_d = 1'b0; mc_d = 2'd0;
      if (phase_q == PH_MAGIC) begin
        if (mag_q && mc_q == 2'd2) begin
          fb_d = val_q != 17'd0;
          phase_d = PH_WIDTH;
        end else begin
          fb_d = 1'b0;
          w_d = '0; h_d = '0;
          phase_d = PH_ERROR;
          t = mk(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0, ERR_MAGIC, 1'b0);
          n_res = 2'd1;
        end
      end else if (bad_q || !dig_q) begin
        if (phase_q <= PH_MAXVAL) begin
          w_d = '0; h_d = '0;
        end
        phase_d = PH_ERROR;
        t = mk(KIND_ERROR, '0, '0, '0, (phase_q <= PH_MAXVAL) ? 16'd0 : w_q,
               (phase_q <= PH_MAXVAL) ? 16'd0 : h_q, fb_q, ERR_TOKEN, 1'b0);
        n_res = 2'd1;
      end else begin
        case (phase_q)
          PH_WIDTH: begin
            w_d = dim_ok ? val_q[15:0] : 16'd0;
            phase_d = PH_HEIGHT;
          end
          PH_HEIGHT: begin
            h_d = dim_ok ? val_q[15:0] : 16'd0;
            phase_d = PH_MAXVAL;
          end
          PH_MAXVAL: begin
            if (w_q == 16'd0 || h_q == 16'd0 || neg || val_q != MaxVal) begin
              w_d = '0; h_d = '0;
              phase_d = PH_ERROR;
              t = mk(KIND_ERROR, '0, '0, '0, '0, '0, fb_q, ERR_HEADER, 1'b0);
            end else begin
              c_d = '0; r_d = '0;
              phase_d = fb_q ? PH_PIX_BIN : PH_PIX_ASCII;
              t = mk(KIND_HEADER, '0, '0, '0, w_q, h_q, fb_q, ERR_MAGIC, 1'b0);
              if (fb_q && req_i.is_cr && !req_i.eof) begin
                acr_d = 1'b1;
              end
            end
            n_res = 2'd1;
          end
          PH_PIX_ASCII: begin
            if (neg || val_q > MaxVal) begin
              phase_d = PH_ERROR;
              t = mk(KIND_ERROR, '0, '0, '0, w_q, h_q, fb_q, ERR_RANGE, 1'b0);
              n_res = 2'd1;
            end else begin
              do_pix = 1'b1;
              pv = val_q[7:0];
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (req_i.eof) begin
      if (do_pix) begin
        t = mk(KIND_PIXEL, pv, c_q, r_q, w_q, h_q, fb_q, ERR_MAGIC, done);
        n_res = 2'd1;
      end
      ra = t;
      if (!(phase_d == PH_DONE || phase_d == PH_ERROR || (do_pix && done))) begin
        rb = mk(KIND_ERROR, '0, '0, '0,
                (phase_d <= PH_MAXVAL) ? 16'd0 : w_d,
                (phase_d <= PH_MAXVAL) ? 16'd0 : h_d, fb_d, ERR_TRUNCATED, 1'b0);
        if (n_res == 2'd0) begin
          ra = rb;
          n_res = 2'd1;
        end else begin
          n_res = 2'd2;
        end
      end
      ra.last_of_run = n_res == 2'd1;
      rb.last_of_run = 1'b1;
      phase_d = PH_MAGIC;
      cmt_d = 1'b0; tok_d = 1'b0; acr_d = 1'b0; val_d = '0; sign_d = 1'b0;
      dig_d = 1'b0; bad_d = 1'b0; mag_d = 1'b0; mc_d = 2'd0;
      w_d = '0; h_d = '0; fb_d = 1'b0; c_d = '0; r_d = '0;
    end else if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
      n_res = 2'd0;
    end else if (cmt_q) begin
      if (req_i.is_lf) begin
        cmt_d = 1'b0;
      end
    end else if (phase_q == PH_PIX_BIN) begin
      acr_d = 1'b0;
      if (!(acr_q && req_i.is_lf)) begin
        ra = mk(KIND_PIXEL, req_i.data, c_q, r_q, w_q, h_q, fb_q, ERR_MAGIC, done);
        ra.last_of_run = 1'b1;
        n_res = 2'd1;
        c_d = cn; r_d = rn;
        if (done) begin
          phase_d = PH_DONE;
        end
      end
    end else if (req_i.ws) begin
      if (do_pix) begin
        t = mk(KIND_PIXEL, pv, c_q, r_q, w_q, h_q, fb_q, ERR_MAGIC, done);
        n_res = 2'd1;
        c_d = cn; r_d = rn;
        if (done) begin
          phase_d = PH_DONE;
        end
      end
      if (req_i.is_hash && phase_d != PH_ERROR) begin
        cmt_d = 1'b1;
      end
      ra = t;
      ra.last_of_run = 1'b1;
    end else begin
      tok_d = 1'b1;
      if (mc_q != 2'd3) begin
        mc_d = mc_q + 2'd1;
      end
      if (phase_q == PH_MAGIC) begin
        if (mc_q == 2'd0) begin
          mag_d = req_i.data == ChP;
        end else if (mc_q == 2'd1) begin
          if (req_i.data != Ch2 && req_i.data != Ch5) begin
            mag_d = 1'b0;
          end
          val_d = (req_i.data == Ch5) ? 17'd1 : 17'd0;
        end else begin
          mag_d = 1'b0;
        end
      end else if (mc_q == 2'd0 && req_i.is_minus) begin
        sign_d = 1'b1;
      end else if (req_i.is_digit) begin
        dig_d = 1'b1;
        if (prod > {4'd0, TokenCap}) begin
          val_d = TokenCap;
          bad_d = bad_q;
        end else begin
          val_d = prod[16:0];
        end
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  logic [1:0] npush;
  assign npush = go ? n_res : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      cmt_q <= 1'b0; tok_q <= 1'b0; acr_q <= 1'b0;
      val_q <= '0; sign_q <= 1'b0; dig_q <= 1'b0; bad_q <= 1'b0; mag_q <= 1'b0;
      mc_q <= '0; w_q <= '0; h_q <= '0; c_q <= '0; r_q <= '0; fb_q <= 1'b0;
      rrd_q <= '0; rwr_q <= '0; rcnt_q <= '0;
    end else begin
      if (go) begin
        phase_q <= phase_d;
        cmt_q <= cmt_d; tok_q <= tok_d; acr_q <= acr_d;
        val_q <= val_d; sign_q <= sign_d; dig_q <= dig_d; bad_q <= bad_d;
        mag_q <= mag_d; mc_q <= mc_d; w_q <= w_d; h_q <= h_d;
        c_q <= c_d; r_q <= r_d; fb_q <= fb_d;
      end
      rwr_q  <= rwr_q + npush;
      if (pop) begin
        rrd_q <= rrd_q + 2'd1;
      end
      rcnt_q <= rcnt_q + {1'b0, npush} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      rq_q[rwr_q] <= ra;
    end
    if (npush == 2'd2) begin
      rq_q[rwr_q + 2'd1] <= rb;
    end
  end
endmodule

FILE: sv/pgm_stream_parser.sv
// Top level of the PGM stream parser.
// Each accepted byte is registered in the front-end request queue, and its results are
// registered in the back-end result queue, from which they are offered.
// Throughput: one byte per cycle while both queues have room; an end of file may give two results,
// which drain from a four-entry result queue at one per cycle while m_axis_tready is high.
// Reset: rst_ni clears the parser to expect a magic token; queues empty.
module pgm_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // pixel_value, col, row, width, height, error_code,
                                      // image_done, 0s
  output logic [2:0]  m_axis_tuser,   // kind, binary_format
  output logic        m_axis_tlast    // last_of_run
);
  import pgm_pkg::*;

  logic req_valid, req_ready;
  req_t req;
  res_t res;

  pgm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_eof_i(s_axis_tuser), .in_data_i(s_axis_tdata),
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  pgm_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {4'd0, res.image_done, res.error_code, res.height, res.width,
                         res.row, res.col, res.pixel_value};
  assign m_axis_tuser = {res.binary_format, res.kind};
  assign m_axis_tlast = res.last_of_run;
endmodule

FILE: dv/pgm_stream_checker.sv
// Checker for the PGM stream parser: predicts results from accepted requests and compares.
module pgm_stream_checker
  import pgm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  phase_e      ph;
  bit          in_cmt, in_tok, aft_cr;
  int unsigned tok_val, tok_chars;
  bit          f_sign, f_dig, f_bad, f_ovf, f_magic;
  int unsigned img_w, img_h, col_cnt, row_cnt;
  bit          fmt_bin;

  res_t        step_res[$];
  res_t        expected_res[$];
  int          fails = 0;
  int          seen = 0;

  assign fail_count_o   = fails;
  assign pending_o      = expected_res.size();
  assign results_seen_o = seen;

  function automatic void parser_clear();
    ph = PH_MAGIC;
    in_cmt = 0; in_tok = 0; aft_cr = 0;
    tok_val = 0; tok_chars = 0;
    {f_sign, f_dig, f_bad, f_ovf, f_magic} = '0;
    img_w = 0; img_h = 0; fmt_bin = 0; col_cnt = 0; row_cnt = 0;
  endfunction

  function automatic void put_res(kind_e k, int unsigned pix, int unsigned c,
                                  int unsigned r, err_e code, bit done);
    res_t x;
    x.kind          = k;
    x.pixel_value   = pix[7:0];
    x.col           = c[15:0];
    x.row           = r[15:0];
    x.width         = img_w[15:0];
    x.height        = img_h[15:0];
    x.binary_format = fmt_bin;
    x.error_code    = code;
    x.image_done    = done;
    x.last_of_run   = 0;
    step_res = {step_res, x};
  endfunction

  function automatic void raise_err(err_e code);
    if (ph <= PH_MAXVAL) begin
      img_w = 0;
      img_h = 0;
    end
    ph = PH_ERROR;
    put_res(KIND_ERROR, 0, 0, 0, code, 0);
  endfunction

  function automatic void emit_pixel(int unsigned v);
    int unsigned c, r;
    bit done;
    c = col_cnt;
    r = row_cnt;
    done = 0;
    col_cnt++;
    if (col_cnt >= img_w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= img_h) begin
        done = 1;
        ph = PH_DONE;
      end
    end
    put_res(KIND_PIXEL, v, c, r, ERR_MAGIC, done);
  endfunction

  function automatic void add_char(logic [7:0] b);
    int unsigned idx;
    idx = tok_chars;
    if (tok_chars < 3) tok_chars++;
    if (ph == PH_MAGIC) begin
      if (idx == 0) begin
        {f_sign, f_dig, f_bad, f_ovf} = '0;
        f_magic = (b == ChP);
      end else if (idx == 1) begin
        if (b != Ch2 && b != Ch5) f_magic = 0;
        tok_val = (b == Ch5) ? 1 : 0;
      end else begin
        f_magic = 0;
      end
    end else if (idx == 0 && b == ChMinus) begin
      f_sign = 1;
    end else if (b >= Ch0 && b <= Ch9) begin
      f_dig = 1;
      tok_val = tok_val * 10 + (b - Ch0);
      if (tok_val > TokenCap) begin
        tok_val = TokenCap;
        f_ovf = 1;
      end
    end else begin
      f_bad = 1;
    end
  endfunction

  function automatic void close_token();
    int unsigned v, cnt;
    bit sg, dg, bd, mg, neg;
    v = tok_val; cnt = tok_chars;
    sg = f_sign; dg = f_dig; bd = f_bad; mg = f_magic;
    in_tok = 0; tok_val = 0; tok_chars = 0;
    {f_sign, f_dig, f_bad, f_ovf, f_magic} = '0;
    if (ph == PH_MAGIC) begin
      if (mg && cnt == 2) begin
        fmt_bin = (v != 0);
        ph = PH_WIDTH;
      end else begin
        fmt_bin = 0;
        raise_err(ERR_MAGIC);
      end
      return;
    end
    if (bd || !dg) begin
      raise_err(ERR_TOKEN);
      return;
    end
    neg = sg && v != 0;
    case (ph)
      PH_WIDTH: begin
        img_w = (!neg && v >= 1 && v <= DimLimit) ? v : 0;
        ph = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        img_h = (!neg && v >= 1 && v <= DimLimit) ? v : 0;
        ph = PH_MAXVAL;
      end
      PH_MAXVAL: begin
        if (img_w == 0 || img_h == 0 || neg || v != MaxVal) begin
          raise_err(ERR_HEADER);
        end else begin
          col_cnt = 0;
          row_cnt = 0;
          ph = fmt_bin ? PH_PIX_BIN : PH_PIX_ASCII;
          put_res(KIND_HEADER, 0, 0, 0, ERR_MAGIC, 0);
        end
      end
      PH_PIX_ASCII: begin
        if (neg || v > MaxVal) raise_err(ERR_RANGE);
        else emit_pixel(v);
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_request(logic eof, logic [7:0] b);
    step_res.delete();
    if (eof) begin
      if (in_tok && ph <= PH_PIX_ASCII) close_token();
      if (ph != PH_DONE && ph != PH_ERROR) raise_err(ERR_TRUNCATED);
      parser_clear();
    end else if (ph == PH_DONE || ph == PH_ERROR) begin
    end else if (in_cmt) begin
      if (b == ChLf) in_cmt = 0;
    end else if (ph == PH_PIX_BIN) begin
      if (aft_cr && b == ChLf) aft_cr = 0;
      else begin
        aft_cr = 0;
        emit_pixel(b);
      end
    end else if (b == 8'h20 || (b >= 8'h09 && b <= ChCr) || b == ChHash) begin
      if (in_tok) begin
        close_token();
        if (b == ChCr && ph == PH_PIX_BIN) aft_cr = 1;
      end
      if (b == ChHash && ph != PH_ERROR) in_cmt = 1;
    end else begin
      in_tok = 1;
      add_char(b);
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last_of_run = 1;
    foreach (step_res[i]) expected_res = {expected_res, step_res[i]};
  endfunction

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      fails++;
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
    end
  endfunction

  initial parser_clear();

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) parse_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen++;
        if (expected_res.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          exp_r = expected_res.pop_front();
          check_field("kind", exp_r.kind, m_axis_tuser[1:0]);
          check_field("binary_format", exp_r.binary_format, m_axis_tuser[2]);
          check_field("pixel_value", exp_r.pixel_value, m_axis_tdata[7:0]);
          check_field("col", exp_r.col, m_axis_tdata[23:8]);
          check_field("row", exp_r.row, m_axis_tdata[39:24]);
          check_field("width", exp_r.width, m_axis_tdata[55:40]);
          check_field("height", exp_r.height, m_axis_tdata[71:56]);
          check_field("error_code", exp_r.error_code, m_axis_tdata[74:72]);
          check_field("image_done", exp_r.image_done, m_axis_tdata[75]);
          check_field("pad", 0, m_axis_tdata[87:76]);
          check_field("last_of_run", exp_r.last_of_run, m_axis_tlast);
        end
      end
    end
  end

endmodule

FILE: dv/tb_pgm_stream_parser.sv
// Testbench top for the PGM stream parser: stimulus, flow control and verdict.
module tb_pgm_stream_parser;
  import pgm_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  int          fail_count, pending, results_seen;
  int          bytes_sent = 0;
  int          files_sent = 0;
  bit          quiet = 0;
  bit          hold_req = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  pgm_stream_parser dut (.*);
  pgm_stream_checker chk (
    .*, .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // request driver
  task automatic send_req(bit eof, logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= eof;
    s_axis_tdata  <= eof ? 8'($urandom) : b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_str(string s);
    foreach (s[i]) send_req(0, s[i]);
  endtask

  task automatic send_eof();
    send_req(1, 0);
    files_sent++;
  endtask

  function automatic string rand_ws();
    case ($urandom_range(0, 7))
      0: return "\t";
      1: return "\n";
      2: return "\v";
      3: return "\f";
      4: return "\r";
      default: return " ";
    endcase
  endfunction

  function automatic string rand_num(int v);
    case ($urandom_range(0, 19))
      0: return "-0";
      1: return $sformatf("-%0d", $urandom_range(1, 300));
      2: return "999999";
      3: return $sformatf("%0da", v);
      4: return "-";
      5: return "+5";
      default: return $sformatf("%0d", v);
    endcase
  endfunction

  // mostly well formed files with random content, some corrupted
  task automatic send_rand_file();
    bit bin, corrupt;
    int w, h, n;
    corrupt = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 12)) send_req(0, 8'($urandom));
      send_eof();
      return;
    end
    bin = $urandom_range(0, 1);
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 3);
    if (corrupt && $urandom_range(0, 3) == 0) send_str(bin ? "P6" : "P2x");
    else send_str(bin ? "P5" : "P2");
    send_str(rand_ws());
    if ($urandom_range(0, 2) == 0) send_str("# c\n");
    send_str((corrupt && $urandom_range(0, 2) == 0) ? rand_num(w) : $sformatf("%0d", w));
    send_str(rand_ws());
    send_str((corrupt && $urandom_range(0, 2) == 0) ? rand_num(h) : $sformatf("%0d", h));
    send_str(rand_ws());
    send_str((corrupt && $urandom_range(0, 2) == 0) ? rand_num(255) : "255");
    n = w * h;
    if (corrupt && $urandom_range(0, 1) == 0) n = $urandom_range(0, n);
    else if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 3);
    if (bin) begin
      case ($urandom_range(0, 3))
        0: send_str("\r\n");
        1: send_str("#x\n");
        default: send_str(rand_ws());
      endcase
      repeat (n) send_req(0, 8'($urandom));
    end else begin
      send_str(rand_ws());
      repeat (n) begin
        send_str(corrupt && $urandom_range(0, 4) == 0 ?
                 rand_num($urandom_range(0, 255)) : $sformatf("%0d", $urandom_range(0, 255)));
        send_str(rand_ws());
      end
    end
    send_eof();
  endtask

  initial begin
    int t;
    rst_ni = 0;
    s_axis_tvalid <= 0;
    s_axis_tuser  <= 0;
    s_axis_tdata  <= 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_eof();
    send_str("P2 2 1 255 0 255 ");
    send_str("x");
    send_eof();
    send_str("P5\n1 1#m\n255\r\n");
    send_req(0, 8'h0a);
    send_eof();
    send_str("P5 1 1 255 ");
    send_req(0, 8'hff);
    send_eof();
    send_str("P3 ");
    send_eof();
    send_str("P2 -3 65536 255 ");
    send_eof();
    send_str("P2 1 1 254 ");
    send_eof();
    send_str("P2 1 2 255 -0 256 ");
    send_eof();
    send_str("P2 2 2 255 7");
    send_eof();

    hold_req = 1;
    while (bytes_sent < 800) begin
      if (bytes_sent > 700) quiet = 1;
      send_rand_file();
    end
    s_axis_tvalid <= 0;

    t = 0;
    while (pending != 0 && t < 20000) begin
      @(posedge clk_i);
      t++;
    end
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests in %0d files; checked %0d results.",
             bytes_sent, files_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result consumer with random and one long stall
  initial begin
    int n;
    m_axis_tready <= 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 0;
        n = 300;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 10);
      end else begin
        m_axis_tready <= 1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
